[hw/rtl/lsb_stego_extractor_top_macros.svh]
// ----------------------------------------------------------------------------
// LSB stego extractor assertion macros
// Concurrent assertion shorthands used by the extractor top.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EXTRACTOR_TOP_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LSBSE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LSBSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lsbse_pkg.sv]
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Shared types and constants for the extractor datapath.
// ----------------------------------------------------------------------------
package lsbse_pkg;

  typedef enum logic [2:0] {
    PH_BEGIN   = 3'd0,
    PH_FLAGS   = 3'd1,
    PH_SIZE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_EXT     = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBI = 2'd2;

  localparam logic [1:0] PART_PAYLOAD = 2'd0;
  localparam logic [1:0] PART_EXT     = 2'd1;
  localparam logic [1:0] PART_EMPTY   = 2'd2;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_NO_EXT = 1'b1;

  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] SEL_MASK    = 8'h06;

  typedef struct packed {
    logic [7:0] carrier_byte;
    logic       start_of_image;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       no_extension;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  part;
    logic        last;
    logic [31:0] payload_length;
    logic        error;
  } result_t;

endpackage

[hw/rtl/lsbse_in_reg.sv]
// ----------------------------------------------------------------------------
// LSB stego extractor input register
// Holds one carrier transaction ahead of the decoder.
// ----------------------------------------------------------------------------
module lsbse_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lsbse_pkg::item_t in_item,
  output logic           q_valid,
  output lsbse_pkg::item_t q_item,
  input  logic           take
);

  logic load;

  assign in_stall = q_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_item <= in_item;
    end
  end

endmodule

[hw/rtl/lsbse_decoder.sv]
// ----------------------------------------------------------------------------
// LSB stego extractor decoder
// Message state and the per-byte decode, one carrier byte per fire.
// ----------------------------------------------------------------------------
module lsbse_decoder #(
  parameter int MAX_EXTENSION = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  lsbse_pkg::cfg_t    cfg,
  input  logic               fire,
  input  lsbse_pkg::item_t   item,
  output logic               emit,
  output lsbse_pkg::result_t result
);

  localparam int EXT_W = $clog2(MAX_EXTENSION + 1);

  lsbse_pkg::phase_t phase, phase_next, ph;
  logic [1:0]       flag_index, flag_index_next, fi;
  logic [3:0]       invert_flags, invert_flags_next, inv;
  logic [7:0]       shift_byte, shift_byte_next, sh;
  logic [2:0]       piece_count, piece_count_next, pc;
  logic [31:0]      length_reg, length_reg_next, len;
  logic [31:0]      byte_count, byte_count_next, bc;
  logic [EXT_W-1:0] extension_count, extension_count_next, ec;

  logic [7:0]  b;
  logic [7:0]  got;
  logic        full;
  logic        bit_in;
  logic [31:0] bc_inc;

  assign b = item.carrier_byte;

  // Piece extraction; got is the shift register with this piece in.
  always_comb begin
    bit_in = b[0];
    if (cfg.mode == lsbse_pkg::MODE_LSB4) begin
      got  = {sh[3:0], 4'(b & lsbse_pkg::NIBBLE_MASK)};
      full = (pc >= 3'd1);
    end else begin
      if (cfg.mode == lsbse_pkg::MODE_LSBI) begin
        // bits 2..1 pick the inversion flag for this byte
        bit_in = b[0] ^ inv[2'((b & lsbse_pkg::SEL_MASK) >> 1)];
      end
      got  = {sh[6:0], bit_in};
      full = (pc >= 3'd7);
    end
  end

  always_comb begin
    // sof clears state before this byte is decoded
    ph  = item.start_of_image ? lsbse_pkg::PH_BEGIN : phase;
    fi  = item.start_of_image ? 2'd0 : flag_index;
    inv = item.start_of_image ? 4'd0 : invert_flags;
    sh  = item.start_of_image ? 8'd0 : shift_byte;
    pc  = item.start_of_image ? 3'd0 : piece_count;
    len = item.start_of_image ? 32'd0 : length_reg;
    bc  = item.start_of_image ? 32'd0 : byte_count;
    ec  = item.start_of_image ? '0 : extension_count;
    if (ph == lsbse_pkg::PH_BEGIN) begin
      ph = (cfg.mode == lsbse_pkg::MODE_LSBI) ? lsbse_pkg::PH_FLAGS : lsbse_pkg::PH_SIZE;
    end
  end

  always_comb begin
    phase_next           = ph;
    flag_index_next      = fi;
    invert_flags_next    = inv;
    shift_byte_next      = sh;
    piece_count_next     = pc;
    length_reg_next      = len;
    byte_count_next      = bc;
    extension_count_next = ec;
    bc_inc               = bc + 32'd1;
    emit                 = 1'b0;
    result.data_byte     = got;
    result.part          = lsbse_pkg::PART_PAYLOAD;
    result.last          = 1'b0;
    result.error         = 1'b0;

    if (ph == lsbse_pkg::PH_SIZE || ph == lsbse_pkg::PH_PAYLOAD ||
        ph == lsbse_pkg::PH_EXT) begin
      shift_byte_next  = full ? 8'd0 : got;
      piece_count_next = full ? 3'd0 : pc + 3'd1;
    end

    case (ph)
      lsbse_pkg::PH_FLAGS: begin
        invert_flags_next[fi] = b[0];
        if (fi == 2'd3) begin
          flag_index_next = 2'd0;
          phase_next      = lsbse_pkg::PH_SIZE;
        end else begin
          flag_index_next = fi + 2'd1;
        end
      end
      lsbse_pkg::PH_SIZE: begin
        if (full) begin
          length_reg_next = {len[23:0], got};
          if (bc_inc < 32'd4) begin
            byte_count_next = bc_inc;
          end else begin
            byte_count_next = 32'd0;
            if (length_reg_next != 32'd0) begin
              phase_next = lsbse_pkg::PH_PAYLOAD;
            end else if (cfg.no_extension) begin
              phase_next       = lsbse_pkg::PH_DONE;
              emit             = 1'b1;
              result.data_byte = 8'd0;
              result.part      = lsbse_pkg::PART_EMPTY;
              result.last      = 1'b1;
            end else begin
              phase_next = lsbse_pkg::PH_EXT;
            end
          end
        end
      end
      lsbse_pkg::PH_PAYLOAD: begin
        if (full) begin
          byte_count_next = bc_inc;
          emit            = 1'b1;
          if (bc_inc >= len) begin
            if (cfg.no_extension) begin
              phase_next  = lsbse_pkg::PH_DONE;
              result.last = 1'b1;
            end else begin
              phase_next = lsbse_pkg::PH_EXT;
            end
          end
        end
      end
      lsbse_pkg::PH_EXT: begin
        if (full) begin
          extension_count_next = ec + EXT_W'(1);
          emit                 = 1'b1;
          result.part          = lsbse_pkg::PART_EXT;
          if (got == 8'd0) begin
            phase_next  = lsbse_pkg::PH_DONE;
            result.last = 1'b1;
          end else if (extension_count_next >= EXT_W'(MAX_EXTENSION)) begin
            phase_next   = lsbse_pkg::PH_DONE;
            result.last  = 1'b1;
            result.error = 1'b1;
          end
        end
      end
      default: begin
        // finished or unused codes: byte ignored
        phase_next = lsbse_pkg::PH_DONE;
      end
    endcase

    result.payload_length = length_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lsbse_pkg::PH_BEGIN;
      flag_index      <= 2'd0;
      invert_flags    <= 4'd0;
      shift_byte      <= 8'd0;
      piece_count     <= 3'd0;
      length_reg      <= 32'd0;
      byte_count      <= 32'd0;
      extension_count <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      flag_index      <= flag_index_next;
      invert_flags    <= invert_flags_next;
      shift_byte      <= shift_byte_next;
      piece_count     <= piece_count_next;
      length_reg      <= length_reg_next;
      byte_count      <= byte_count_next;
      extension_count <= extension_count_next;
    end
  end

endmodule

[hw/rtl/lsbse_out_reg.sv]
// ----------------------------------------------------------------------------
// LSB stego extractor output register
// Holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module lsbse_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  lsbse_pkg::result_t d,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output lsbse_pkg::result_t q
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      q <= d;
    end
  end

endmodule

[hw/rtl/lsb_stego_extractor_top.sv]
// ----------------------------------------------------------------------------
// LSB stego extractor
// Recovers a hidden message from the LSBs of carrier pixel bytes.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  -----------------------------------
//  in       sink       in_valid / in_stall    carrier_byte, start_of_image
//  out      source     out_valid / out_stall  data_byte, part, last,
//                                             payload_length, error
//  cfg      sink       cfg_we                 cfg_index, cfg_data
//
//  One carrier byte per cycle while out is not stalled; a result passes through the
//  input register, then is decoded into the output register.
//  The decoder state loop (shift byte, counters, phase) updates on each fire.
//  Reset is synchronous: phase returns to begin, counters and flags clear,
//  mode and no_extension clear to zero. No clearing pass is needed.
//  A stall on out holds the decoder; in stalls only once its register is full.
//
`include "lsb_stego_extractor_top_macros.svh"

module lsb_stego_extractor_top #(
  parameter int MAX_EXTENSION = 8
) (
  input  logic        clk,
  input  logic        rst,
  // carrier transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  carrier_byte,
  input  logic        start_of_image,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [1:0]  part,
  output logic        last,
  output logic [31:0] payload_length,
  output logic        error,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  lsbse_pkg::cfg_t    cfg;
  lsbse_pkg::item_t   in_item;
  lsbse_pkg::item_t   q_item;
  lsbse_pkg::result_t dec_result;
  lsbse_pkg::result_t out_result;
  logic               q_valid;
  logic               out_free;
  logic               fire;
  logic               emit;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lsbse_pkg::REG_MODE:   cfg.mode         <= cfg_data;
        lsbse_pkg::REG_NO_EXT: cfg.no_extension <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item.carrier_byte   = carrier_byte;
  assign in_item.start_of_image = start_of_image;

  // A held byte is decoded whenever the output register can take a result.
  assign fire = q_valid && out_free;

  lsbse_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .take     (fire)
  );

  lsbse_decoder #(
    .MAX_EXTENSION (MAX_EXTENSION)
  ) u_decoder (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (q_item),
    .emit   (emit),
    .result (dec_result)
  );

  lsbse_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && emit),
    .d         (dec_result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q         (out_result)
  );

  assign data_byte      = out_result.data_byte;
  assign part           = out_result.part;
  assign last           = out_result.last;
  assign payload_length = out_result.payload_length;
  assign error          = out_result.error;

  // Assertions
  `LSBSE_ASSERT_IMPL(a_stall_needs_held, clk, rst, in_stall, q_valid,
                     "stall with empty input register")
  `LSBSE_ASSERT_IMPL(a_error_is_last, clk, rst, out_valid && error,
                     last && (part == lsbse_pkg::PART_EXT),
                     "error not on last extension byte")
  `LSBSE_ASSERT_IMPL(a_payload_len, clk, rst,
                     out_valid && (part == lsbse_pkg::PART_PAYLOAD),
                     payload_length != 32'd0, "payload byte with zero length")
  `LSBSE_ASSERT_NEXT(a_marker_ends, clk, rst,
                     out_valid && !out_stall && (part == lsbse_pkg::PART_EMPTY),
                     !out_valid || start_of_image || $past(q_item.start_of_image),
                     "result after empty marker")

endmodule
